@@ design/hkst_pkg.sv @@
// shared constants and payload types for the held key slot table
package hkst_pkg;

  localparam int KEY_W = 16;
  localparam int ACT_W = 2;

  // action codes; the spare code behaves as a query
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SPARE  = 2'd3;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [ACT_W-1:0] action_t;

endpackage

@@ design/hkst_if.sv @@
// valid/ready channels for command items and result items
interface hkst_cmd_if;
  logic                 valid;
  logic                 ready;
  hkst_pkg::action_t    action;
  hkst_pkg::key_t       key_code;

  modport source (output valid, output action, output key_code, input ready);
  modport sink   (input valid, input action, input key_code, output ready);
endinterface

interface hkst_res_if;
  logic valid;
  logic ready;
  logic key_found;
  logic dropped;

  modport source (output valid, output key_found, output dropped, input ready);
  modport sink   (input valid, input key_found, input dropped, output ready);
endinterface

@@ design/held_key_slot_table_unit.sv @@
// held key slot table: top level with input register, table and result register
//
//   channel | dir | handshake   | payload
//   cmd     | in  | valid/ready | action[1:0], key_code[15:0]
//   res     | out | valid/ready | key_found, dropped
//
// an item passes through the input register and then the result register;
// one item per cycle is sustained while res is not stalled.
// the compare against all slots and the free-slot priority search lie between
// the input register and the table/result registers.
// rst clears the valid bits, the used count and both stage valids; keys are not reset.
// when res is stalled the input register holds and cmd.ready drops once it is full.
module held_key_slot_table_unit #(
  parameter int SLOTS = 10
) (
  input logic       clk,
  input logic       rst,
  hkst_cmd_if.sink  cmd,
  hkst_res_if.source res
);
  import hkst_pkg::*;

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // input register
  logic    s1_valid;
  action_t s1_action;
  key_t    s1_key;

  // table
  logic [SLOTS-1:0][KEY_W-1:0] slot_key;
  logic [SLOTS-1:0]            slot_valid;
  logic [SLOTS-1:0]            slot_valid_next;
  logic [CNT_W-1:0]            slots_used;
  logic [CNT_W-1:0]            slots_used_next;

  logic [SLOTS-1:0] hit;
  logic             found;
  logic             free_hit;
  logic [IDX_W-1:0] free_idx;

  logic             advance;
  logic             key_we;
  logic [IDX_W-1:0] key_idx;
  logic             drop;

  assign advance   = s1_valid && (!res.valid || res.ready);
  assign cmd.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_action <= cmd.action;
      s1_key    <= cmd.key_code;
    end
  end

  hkst_lookup #(
    .SLOTS (SLOTS),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_lookup (
    .key        (s1_key),
    .slot_key   (slot_key),
    .slot_valid (slot_valid),
    .slots_used (slots_used),
    .hit        (hit),
    .found      (found),
    .free_hit   (free_hit),
    .free_idx   (free_idx)
  );

  always_comb begin
    slot_valid_next = slot_valid;
    slots_used_next = slots_used;
    key_we          = 1'b0;
    key_idx         = free_idx;
    drop            = 1'b0;
    case (s1_action)
      ACT_INSERT: begin
        if (!found) begin
          if (free_hit) begin
            key_we = 1'b1;
          end else if (slots_used < CNT_W'(SLOTS)) begin
            key_we          = 1'b1;
            key_idx         = slots_used[IDX_W-1:0];
            slots_used_next = slots_used + CNT_W'(1);
          end else begin
            drop = 1'b1;
          end
        end
        if (key_we) begin
          slot_valid_next[key_idx] = 1'b1;
        end
      end
      ACT_REMOVE: begin
        slot_valid_next = slot_valid & ~hit;
      end
      ACT_QUERY, ACT_SPARE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slots_used <= '0;
    end else if (advance) begin
      slot_valid <= slot_valid_next;
      slots_used <= slots_used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && key_we) begin
      slot_key[key_idx] <= s1_key;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.key_found <= found;
      res.dropped   <= drop;
    end
  end

  // valid slots lie below the used count
  logic [SLOTS-1:0] below_used;
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      below_used[i] = CNT_W'(i) < slots_used;
    end
  end

  a_valid_below_used: assert property (@(posedge clk) disable iff (rst)
    (slot_valid & ~below_used) == '0)
    else $error("valid slot at or above used count");

  a_used_never_shrinks: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> slots_used >= $past(slots_used))
    else $error("used count decreased");

  a_drop_only_when_full: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.dropped |-> slots_used == CNT_W'(SLOTS) && !res.key_found)
    else $error("drop reported while table not full or key held");

endmodule

@@ design/hkst_lookup.sv @@
// parallel key compare and highest free slot search over the table
module hkst_lookup #(
  parameter int SLOTS = 10,
  parameter int CNT_W = 4,
  parameter int IDX_W = 4
) (
  input  hkst_pkg::key_t                   key,
  input  logic [SLOTS-1:0][hkst_pkg::KEY_W-1:0] slot_key,
  input  logic [SLOTS-1:0]                 slot_valid,
  input  logic [CNT_W-1:0]                 slots_used,
  output logic [SLOTS-1:0]                 hit,
  output logic                             found,
  output logic                             free_hit,
  output logic [IDX_W-1:0]                 free_idx
);
  import hkst_pkg::*;

  always_comb begin
    hit = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = slot_valid[i] && (slot_key[i] == key);
    end
    found = |hit;
  end

  // later slots override earlier ones, so the highest free slot wins
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if ((CNT_W'(i) < slots_used) && !slot_valid[i]) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

endmodule
